[sv/kssd_pkg.sv]
// Shared types, constants and key decode for the keypad shift scanner.
package kssd_pkg;

    localparam int unsigned SHIFT_BITS = 8;
    localparam int unsigned TIMER_W    = 20;
    localparam int unsigned BITCNT_W   = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HALF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd2;

    localparam logic [7:0]         LOAD_LOW_RST   = 8'd5;
    localparam logic [7:0]         CLOCK_HALF_RST = 8'd1;
    localparam logic [TIMER_W-1:0] DEBOUNCE_RST   = 20'd20000;

    typedef struct packed {
        logic [7:0]         load_low_ticks;
        logic [7:0]         clock_half_ticks;
        logic [TIMER_W-1:0] debounce_ticks;
    } cfg_t;

    typedef struct packed {
        logic       load_n;
        logic       shift_clock;
        logic       key_valid;
        logic [7:0] key_code;
    } result_t;

    // index of lowest set bit, 3 when only bit 3 (or none) is set
    function automatic logic [1:0] lowest_index(input logic [3:0] nib);
        logic [1:0] idx;
        if (nib[0]) begin
            idx = 2'd0;
        end else if (nib[1]) begin
            idx = 2'd1;
        end else if (nib[2]) begin
            idx = 2'd2;
        end else begin
            idx = 2'd3;
        end
        return idx;
    endfunction

    // rows in low nibble, columns in high nibble, both active low
    function automatic logic [7:0] decode_key(input logic [7:0] byte_in);
        logic [3:0] rows;
        logic [3:0] cols;
        logic [3:0] sel;
        logic [7:0] code;
        rows = ~byte_in[3:0];
        cols = ~byte_in[7:4];
        sel  = {lowest_index(rows), lowest_index(cols)};
        case (sel)
            4'h0:    code = "1";
            4'h1:    code = "2";
            4'h2:    code = "3";
            4'h3:    code = "A";
            4'h4:    code = "4";
            4'h5:    code = "5";
            4'h6:    code = "6";
            4'h7:    code = "B";
            4'h8:    code = "7";
            4'h9:    code = "8";
            4'hA:    code = "9";
            4'hB:    code = "C";
            4'hC:    code = "*";
            4'hD:    code = "0";
            4'hE:    code = "#";
            default: code = "D";
        endcase
        if (rows == 4'h0 || cols == 4'h0) begin
            code = 8'h00;
        end
        return code;
    endfunction

endpackage

[sv/kssd_cfg.sv]
// Configuration register file for the keypad shift scanner.
module kssd_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kssd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kssd_pkg::CFG_DATA_W-1:0] cfg_data,
    output kssd_pkg::cfg_t                 cfg
);
    import kssd_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.load_low_ticks   <= LOAD_LOW_RST;
            cfg_reg.clock_half_ticks <= CLOCK_HALF_RST;
            cfg_reg.debounce_ticks   <= DEBOUNCE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LOAD_LOW:   cfg_reg.load_low_ticks   <= cfg_data[7:0];
                CFG_CLOCK_HALF: cfg_reg.clock_half_ticks <= cfg_data[7:0];
                CFG_DEBOUNCE:   cfg_reg.debounce_ticks   <= cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

[sv/kssd_scan.sv]
// Scan sequencer: pin timing, bit capture, decode and debounce, one tick per step.
module kssd_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              serial_in,
    input  kssd_pkg::cfg_t    cfg,
    output kssd_pkg::result_t result
);
    import kssd_pkg::*;

    typedef enum logic [1:0] {
        PH_LOAD = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_FIRST   = 2'd0,
        ST_CONFIRM = 2'd1,
        ST_RELEASE = 2'd2
    } stage_t;

    phase_t              phase_reg,  phase_next;
    stage_t              stage_reg,  stage_next;
    logic [TIMER_W-1:0]  timer_reg,  timer_next;
    logic [BITCNT_W-1:0] bits_reg,   bits_next;
    logic [7:0]          shift_reg,  shift_next;
    logic [7:0]          first_reg,  first_next;

    logic [TIMER_W-1:0]  timer_inc;
    logic [7:0]          half;
    logic [7:0]          load_len;
    logic [TIMER_W-1:0]  deb_len;
    logic [7:0]          key;
    logic [BITCNT_W-1:0] bits_inc;

    always_comb begin
        timer_inc = timer_reg + 1'b1;
        half      = (cfg.clock_half_ticks == 8'd0) ? 8'd1 : cfg.clock_half_ticks;
        load_len  = (cfg.load_low_ticks == 8'd0) ? 8'd1 : cfg.load_low_ticks;
        deb_len   = (cfg.debounce_ticks == '0) ? TIMER_W'(1) : cfg.debounce_ticks;
        key       = decode_key(shift_reg);
        bits_inc  = bits_reg + 1'b1;

        phase_next = phase_reg;
        stage_next = stage_reg;
        timer_next = timer_inc;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        first_next = first_reg;

        result.load_n      = 1'b1;
        result.shift_clock = 1'b1;
        result.key_valid   = 1'b0;
        result.key_code    = 8'h00;

        case (phase_reg)
            PH_LOW: begin
                result.shift_clock = 1'b0;
                if (timer_inc >= TIMER_W'(half)) begin
                    shift_next = {shift_reg[6:0], serial_in};
                    timer_next = '0;
                    phase_next = PH_HIGH;
                end
            end
            PH_HIGH: begin
                if (timer_inc >= TIMER_W'(half)) begin
                    timer_next = '0;
                    bits_next  = bits_inc;
                    if (bits_inc >= BITCNT_W'(SHIFT_BITS)) begin
                        phase_next = PH_LOAD;
                        case (stage_reg)
                            ST_CONFIRM: begin
                                if (key == first_reg) begin
                                    stage_next = ST_RELEASE;
                                end else begin
                                    stage_next = ST_FIRST;
                                    first_next = 8'h00;
                                end
                            end
                            ST_RELEASE: begin
                                if (key == 8'h00) begin
                                    result.key_valid = 1'b1;
                                    result.key_code  = first_reg;
                                    stage_next       = ST_FIRST;
                                    first_next       = 8'h00;
                                end
                            end
                            default: begin
                                stage_next = ST_FIRST;
                                if (key != 8'h00) begin
                                    first_next = key;
                                    stage_next = ST_CONFIRM;
                                    phase_next = PH_WAIT;
                                end
                            end
                        endcase
                    end else begin
                        phase_next = PH_LOW;
                    end
                end
            end
            PH_WAIT: begin
                if (timer_inc >= deb_len) begin
                    timer_next = '0;
                    phase_next = PH_LOAD;
                end
            end
            default: begin
                result.load_n = 1'b0;
                if (timer_inc >= TIMER_W'(load_len)) begin
                    timer_next = '0;
                    bits_next  = '0;
                    shift_next = 8'h00;
                    phase_next = PH_LOW;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LOAD;
            stage_reg <= ST_FIRST;
            timer_reg <= '0;
            bits_reg  <= '0;
            shift_reg <= 8'h00;
            first_reg <= 8'h00;
        end else if (step) begin
            phase_reg <= phase_next;
            stage_reg <= stage_next;
            timer_reg <= timer_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            first_reg <= first_next;
        end
    end

endmodule

[sv/keypad_shift_scan_debounce.sv]
// Top level: tick input register, scan sequencer, config registers, result register.
// Each input transfer is one tick carrying the serial pin level; every tick yields
// exactly one result (load pin, clock pin, key flag and ASCII code). Ticks go
// through an input register, one pass of scan logic and an output register, so a
// tick is accepted every cycle while the result side keeps taking; the result is
// presented from the output register and transfers when the result side takes
// it. Backpressure on the result side holds the input register and stops the
// scan state, so no tick is lost. Config writes are taken every cycle and should
// only be issued while no tick is in flight.
module keypad_shift_scan_debounce (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] serial_in
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [0] load_n, [1] shift_clock,
                                                       // [9:2] key_code
    output logic                            m_tuser,   // [0] key_valid
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kssd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kssd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kssd_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t out_reg;
    logic    in_valid_reg;
    logic    serial_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    kssd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kssd_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .serial_in (serial_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            serial_reg <= s_tdata[0];
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.key_code, out_reg.shift_clock, out_reg.load_n};
    assign m_tuser  = out_reg.key_valid;

endmodule
